FILE: sv/ultrasonic_obstacle_avoid_sequencer_macros.svh
`ifndef ULTRASONIC_OBSTACLE_AVOID_SEQUENCER_MACROS_SVH
`define ULTRASONIC_OBSTACLE_AVOID_SEQUENCER_MACROS_SVH

// invariant checked at every edge out of reset
`define UOAS_CHECK(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequence checked in the cycle after the trigger
`define UOAS_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/uoas_pkg.sv
`default_nettype none

package uoas_pkg;

    localparam int ECHO_W = 16;
    localparam int D16_W  = 15;
    localparam int DVS_W  = 14;
    localparam int QCNT_W = 4;
    localparam int DUTY_W = 8;
    localparam int HOLD_W = 8;
    localparam int DCM_W  = 11;
    localparam int DIR_W  = 2;
    localparam int CM_W   = 10;
    localparam int IDX_W  = 3;

    localparam logic [DIR_W-1:0] DIR_OFF  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BACK = 2'd2;

    localparam logic [IDX_W-1:0] CFG_CRITICAL     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_WARNING      = 3'd1;
    localparam logic [IDX_W-1:0] CFG_SAFE         = 3'd2;
    localparam logic [IDX_W-1:0] CFG_BACKUP_MS    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_BRAKE_MS     = 3'd4;
    localparam logic [IDX_W-1:0] CFG_TURN_MS      = 3'd5;
    localparam logic [IDX_W-1:0] CFG_BACKUP_SPEED = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SLOW_SPEED   = 3'd7;

    localparam logic [2:0] STEP_REVERSE = 3'd0;
    localparam logic [2:0] STEP_BRAKE   = 3'd1;
    localparam logic [2:0] STEP_STOP_A  = 3'd2;
    localparam logic [2:0] STEP_TURN    = 3'd3;
    localparam logic [2:0] STEP_STOP_B  = 3'd4;

    typedef struct packed {
        logic [CM_W-1:0]   critical_cm;
        logic [CM_W-1:0]   warning_cm;
        logic [CM_W-1:0]   safe_cm;
        logic [HOLD_W-1:0] backup_ms;
        logic [HOLD_W-1:0] brake_ms;
        logic [HOLD_W-1:0] turn_ms;
        logic [DUTY_W-1:0] backup_speed;
        logic [DUTY_W-1:0] slow_speed;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [DVS_W-1:0]  hi;
        logic [D16_W-1:0]  lo;
        logic [DVS_W-1:0]  dvs;
        logic [QCNT_W-1:0] cnt;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [D16_W-1:0] q;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: sv/uoas_div.sv
`default_nettype none

module uoas_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  uoas_pkg::t_div_req i_req,
    output uoas_pkg::t_div_rsp o_rsp
);
    import uoas_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [QCNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [D16_W-1:0]  r_lo;
    logic [D16_W-1:0]  r_q;

    logic [DVS_W:0] w_sh;
    logic [DVS_W:0] w_diff;
    logic           w_ge;

    assign w_sh   = {r_rem, r_lo[D16_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_dvs};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.cnt;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == QCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.hi;
            r_dvs <= i_req.dvs;
            r_lo  <= i_req.lo;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_sh[DVS_W-1:0];
            r_lo  <= {r_lo[D16_W-2:0], 1'b0};
            r_q   <= {r_q[D16_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;

endmodule

`default_nettype wire

FILE: sv/uoas_seq.sv
`default_nettype none
`include "ultrasonic_obstacle_avoid_sequencer_macros.svh"

module uoas_seq #(
    parameter int SAMPLES = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  uoas_pkg::t_cfg                      i_cfg,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [uoas_pkg::ECHO_W-1:0]         i_echo_us,
    output uoas_pkg::t_div_req                  o_div_req,
    input  uoas_pkg::t_div_rsp                  i_div_rsp,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [uoas_pkg::DIR_W-1:0]          o_left_dir,
    output logic [uoas_pkg::DIR_W-1:0]          o_right_dir,
    output logic [uoas_pkg::DUTY_W-1:0]         o_left_duty,
    output logic [uoas_pkg::DUTY_W-1:0]         o_right_duty,
    output logic [uoas_pkg::HOLD_W-1:0]         o_hold_ms,
    output logic [uoas_pkg::DCM_W-1:0]          o_distance_cm,
    output logic                                o_last
);
    import uoas_pkg::*;

    localparam int SUM_W  = $clog2(SAMPLES * 65535 + 1);
    localparam int CNT_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int MUL2_W = D16_W + 8;
    localparam int RCP_SH = 32;
    localparam int PROD_W = SUM_W + RCP_SH;
    // ceil(2^32 * 272 / (1000 * SAMPLES)); the floor is exact for every reachable sum
    localparam logic [RCP_SH-1:0] AVG_RECIP = RCP_SH'(
        ((64'd272 << RCP_SH) + 64'(1000 * SAMPLES) - 64'd1) / 64'(1000 * SAMPLES));

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_CLASS = 5'b00100,
        S_DIV2  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_cnt;
    logic [D16_W-1:0]   r_d16;
    logic [DUTY_W-1:0]  r_duty;
    logic               r_man;
    logic [2:0]         r_idx;

    logic               r_out_valid;
    logic [DIR_W-1:0]   r_left_dir, r_right_dir;
    logic [DUTY_W-1:0]  r_left_duty, r_right_duty;
    logic [HOLD_W-1:0]  r_hold_ms;
    logic [DCM_W-1:0]   r_distance_cm;
    logic               r_last;

    logic               w_in_acc;
    logic               w_close;
    logic [PROD_W-1:0]  w_avg_prod;
    logic [MUL2_W-1:0]  w_num2;
    logic [D16_W-1:0]   w_crit16, w_warn16, w_safe16;
    logic               w_is_man, w_is_slow, w_is_full;
    logic               w_load, w_last_item;
    logic [15:0]        w_rtrim_p, w_ltrim_p;
    logic [DIR_W-1:0]   w_ld, w_rd;
    logic [DUTY_W-1:0]  w_lduty, w_rduty;
    logic [HOLD_W-1:0]  w_hold;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_close    = (r_cnt == CNT_W'(SAMPLES - 1));

    assign w_avg_prod = PROD_W'(r_sum) * PROD_W'(AVG_RECIP);
    assign w_num2     = {r_d16, 8'h00} - MUL2_W'(r_d16);

    assign w_crit16  = D16_W'({i_cfg.critical_cm, 4'h0});
    assign w_warn16  = D16_W'({i_cfg.warning_cm, 4'h0});
    assign w_safe16  = D16_W'({i_cfg.safe_cm, 4'h0});
    assign w_is_man  = r_d16 <= w_crit16;
    assign w_is_slow = r_d16 < w_warn16;
    assign w_is_full = r_d16 > w_safe16;

    always_comb begin
        o_div_req       = '0;
        o_div_req.start = 1'b0;
        unique case (r_state)
            S_CLASS: begin
                o_div_req.start = !w_is_man && !w_is_slow && !w_is_full;
                o_div_req.hi    = w_num2[DVS_W+7:8];
                o_div_req.lo    = {w_num2[DUTY_W-1:0], (D16_W - DUTY_W)'(0)};
                o_div_req.dvs   = (i_cfg.safe_cm == '0) ? DVS_W'(16)
                                                        : {i_cfg.safe_cm, 4'h0};
                o_div_req.cnt   = QCNT_W'(DUTY_W);
            end
            default: ;
        endcase
    end

    assign w_load      = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    assign w_last_item = !r_man || (r_idx == STEP_STOP_B);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc && w_close) n_state = S_MUL;
            S_MUL:   n_state = S_CLASS;
            S_CLASS: n_state = o_div_req.start ? S_DIV2 : S_EMIT;
            S_DIV2:  if (i_div_rsp.done) n_state = S_EMIT;
            S_EMIT:  if (w_load && w_last_item) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_man       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_sum <= r_sum + SUM_W'(i_echo_us);
                r_cnt <= w_close ? '0 : r_cnt + 1'b1;
            end
            if (r_state == S_MUL) begin
                r_sum <= '0;
            end
            if (r_state == S_CLASS) begin
                r_man <= w_is_man;
                r_idx <= STEP_REVERSE;
            end
            if (w_load) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_d16 <= w_avg_prod[RCP_SH +: D16_W];
        end
        if (r_state == S_CLASS) begin
            if (w_is_slow) begin
                r_duty <= i_cfg.slow_speed;
            end else begin
                r_duty <= '1;
            end
        end
        if (r_state == S_DIV2 && i_div_rsp.done) begin
            r_duty <= i_div_rsp.q[DUTY_W-1:0];
        end
    end

    assign w_rtrim_p = 16'(i_cfg.backup_speed) * 16'd197;
    assign w_ltrim_p = 16'(r_duty) * 16'd243;

    always_comb begin
        w_ld    = DIR_OFF;
        w_rd    = DIR_OFF;
        w_lduty = '0;
        w_rduty = '0;
        w_hold  = '0;
        if (!r_man) begin
            w_ld    = DIR_FWD;
            w_rd    = DIR_FWD;
            w_lduty = w_ltrim_p[15:8];
            w_rduty = r_duty;
        end else begin
            unique case (r_idx)
                STEP_REVERSE: begin
                    w_ld    = DIR_BACK;
                    w_rd    = DIR_BACK;
                    w_lduty = i_cfg.backup_speed;
                    w_rduty = w_rtrim_p[15:8];
                    w_hold  = i_cfg.backup_ms;
                end
                STEP_BRAKE: begin
                    w_ld    = DIR_FWD;
                    w_rd    = DIR_BACK;
                    w_lduty = i_cfg.backup_speed;
                    w_rduty = w_rtrim_p[15:8];
                    w_hold  = i_cfg.brake_ms;
                end
                STEP_TURN: begin
                    w_ld    = DIR_FWD;
                    w_rd    = DIR_BACK;
                    w_lduty = i_cfg.slow_speed;
                    w_rduty = i_cfg.slow_speed;
                    w_hold  = i_cfg.turn_ms;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_left_dir    <= w_ld;
            r_right_dir   <= w_rd;
            r_left_duty   <= w_lduty;
            r_right_duty  <= w_rduty;
            r_hold_ms     <= w_hold;
            r_distance_cm <= r_d16[D16_W-1:4];
            r_last        <= w_last_item;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_dir    = r_left_dir;
    assign o_right_dir   = r_right_dir;
    assign o_left_duty   = r_left_duty;
    assign o_right_duty  = r_right_duty;
    assign o_hold_ms     = r_hold_ms;
    assign o_distance_cm = r_distance_cm;
    assign o_last        = r_last;

    `UOAS_CHECK(a_done_in_div, !i_div_rsp.done || r_state == S_DIV2, "stray divider done")
    `UOAS_CHECK_NEXT(a_close_window, w_in_acc && w_close, r_state == S_MUL, "window close missed")
    `UOAS_CHECK_NEXT(a_last_to_idle, w_load && w_last_item, !o_in_stall && o_last, "final beat")

endmodule

`default_nettype wire

FILE: sv/ultrasonic_obstacle_avoid_sequencer.sv
// channel   dir  handshake                    payload
// input     in   i_in_valid / o_in_stall      i_echo_us
// result    out  o_out_valid / i_out_stall    o_left_dir .. o_last
// config    in   i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A sample that does not close the window is only added to the sum, and the input stays open.
// A closing sample is accepted, then the reciprocal multiply forms the average, then
// it is classified; when the duty is scaled it then goes to the restoring divider (one
// quotient bit per cycle), and the result follows as 1 or 5 result beats.
// Reset is synchronous, active low; it clears the sum and count and loads the config defaults.
// o_in_stall is high from a closing sample until the final result beat is loaded;
// a stalled result beat holds in the output register.
`default_nettype none

module ultrasonic_obstacle_avoid_sequencer #(
    parameter int SAMPLES = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [uoas_pkg::ECHO_W-1:0]     i_echo_us,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [uoas_pkg::DIR_W-1:0]      o_left_dir,
    output logic [uoas_pkg::DIR_W-1:0]      o_right_dir,
    output logic [uoas_pkg::DUTY_W-1:0]     o_left_duty,
    output logic [uoas_pkg::DUTY_W-1:0]     o_right_duty,
    output logic [uoas_pkg::HOLD_W-1:0]     o_hold_ms,
    output logic [uoas_pkg::DCM_W-1:0]      o_distance_cm,
    output logic                            o_last,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [uoas_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [uoas_pkg::CM_W-1:0]       i_cfg_data
);
    import uoas_pkg::*;

    t_cfg     r_cfg;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.critical_cm  <= CM_W'(40);
            r_cfg.warning_cm   <= CM_W'(80);
            r_cfg.safe_cm      <= CM_W'(120);
            r_cfg.backup_ms    <= HOLD_W'(70);
            r_cfg.brake_ms     <= HOLD_W'(15);
            r_cfg.turn_ms      <= HOLD_W'(50);
            r_cfg.backup_speed <= DUTY_W'(150);
            r_cfg.slow_speed   <= DUTY_W'(100);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CRITICAL:     r_cfg.critical_cm  <= i_cfg_data;
                CFG_WARNING:      r_cfg.warning_cm   <= i_cfg_data;
                CFG_SAFE:         r_cfg.safe_cm      <= i_cfg_data;
                CFG_BACKUP_MS:    r_cfg.backup_ms    <= i_cfg_data[HOLD_W-1:0];
                CFG_BRAKE_MS:     r_cfg.brake_ms     <= i_cfg_data[HOLD_W-1:0];
                CFG_TURN_MS:      r_cfg.turn_ms      <= i_cfg_data[HOLD_W-1:0];
                CFG_BACKUP_SPEED: r_cfg.backup_speed <= i_cfg_data[DUTY_W-1:0];
                CFG_SLOW_SPEED:   r_cfg.slow_speed   <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    uoas_seq #(
        .SAMPLES (SAMPLES)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_echo_us     (i_echo_us),
        .o_div_req     (w_div_req),
        .i_div_rsp     (w_div_rsp),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_left_dir    (o_left_dir),
        .o_right_dir   (o_right_dir),
        .o_left_duty   (o_left_duty),
        .o_right_duty  (o_right_duty),
        .o_hold_ms     (o_hold_ms),
        .o_distance_cm (o_distance_cm),
        .o_last        (o_last)
    );

    uoas_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

endmodule

`default_nettype wire

FILE: test/uoas_checker.sv
`timescale 1ns / 100ps

module uoas_checker #(
    parameter int SAMPLES = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [uoas_pkg::ECHO_W-1:0]     i_echo_us,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [uoas_pkg::DIR_W-1:0]      i_left_dir,
    input  logic [uoas_pkg::DIR_W-1:0]      i_right_dir,
    input  logic [uoas_pkg::DUTY_W-1:0]     i_left_duty,
    input  logic [uoas_pkg::DUTY_W-1:0]     i_right_duty,
    input  logic [uoas_pkg::HOLD_W-1:0]     i_hold_ms,
    input  logic [uoas_pkg::DCM_W-1:0]      i_distance_cm,
    input  logic                            i_last,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [uoas_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [uoas_pkg::CM_W-1:0]       i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_beats
);
    import uoas_pkg::*;

    typedef struct packed {
        logic [DIR_W-1:0]  left_dir;
        logic [DIR_W-1:0]  right_dir;
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic [HOLD_W-1:0] hold_ms;
        logic [DCM_W-1:0]  distance_cm;
        logic              last;
    } t_motor_cmd;

    t_motor_cmd  motor_cmds[$];
    t_cfg        cfg;
    logic [31:0] echo_sum;
    int          window_fill;
    int          mismatches = 0;
    int          beats = 0;

    function automatic t_motor_cmd make_cmd(
        input logic [DIR_W-1:0] ld, input logic [DIR_W-1:0] rd,
        input logic [DUTY_W-1:0] lduty, input logic [DUTY_W-1:0] rduty,
        input logic [HOLD_W-1:0] hold, input logic [DCM_W-1:0] dcm, input logic last);
        t_motor_cmd c;
        c.left_dir = ld;
        c.right_dir = rd;
        c.left_duty = lduty;
        c.right_duty = rduty;
        c.hold_ms = hold;
        c.distance_cm = dcm;
        c.last = last;
        return c;
    endfunction

    // accumulate one echo; on the closing sample of a window queue the commands
    task automatic take_echo(input logic [ECHO_W-1:0] echo);
        longint            d16;
        int                duty;
        int                safe16;
        logic [DUTY_W-1:0] rtrim;
        logic [DCM_W-1:0]  dcm;
        echo_sum = echo_sum + echo;
        window_fill++;
        if (window_fill < SAMPLES) return;
        d16 = (longint'(echo_sum) * 272) / (1000 * SAMPLES);
        echo_sum = '0;
        window_fill = 0;
        dcm = DCM_W'(d16 >> 4);
        if (d16 <= 16 * longint'(cfg.critical_cm)) begin
            rtrim = DUTY_W'((int'(cfg.backup_speed) * 197) >> 8);
            motor_cmds.push_back(make_cmd(DIR_BACK, DIR_BACK, cfg.backup_speed, rtrim,
                                          cfg.backup_ms, dcm, 1'b0));
            motor_cmds.push_back(make_cmd(DIR_FWD, DIR_BACK, cfg.backup_speed, rtrim,
                                          cfg.brake_ms, dcm, 1'b0));
            motor_cmds.push_back(make_cmd(DIR_OFF, DIR_OFF, '0, '0, '0, dcm, 1'b0));
            motor_cmds.push_back(make_cmd(DIR_FWD, DIR_BACK, cfg.slow_speed, cfg.slow_speed,
                                          cfg.turn_ms, dcm, 1'b0));
            motor_cmds.push_back(make_cmd(DIR_OFF, DIR_OFF, '0, '0, '0, dcm, 1'b1));
        end else begin
            if (d16 < 16 * longint'(cfg.warning_cm)) begin
                duty = cfg.slow_speed;
            end else if (d16 > 16 * longint'(cfg.safe_cm)) begin
                duty = 255;
            end else begin
                safe16 = 16 * (cfg.safe_cm != 0 ? int'(cfg.safe_cm) : 1);
                duty = int'((255 * d16) / safe16);
                if (duty > 255) duty = 255;
            end
            motor_cmds.push_back(make_cmd(DIR_FWD, DIR_FWD, DUTY_W'((duty * 243) >> 8),
                                          DUTY_W'(duty), '0, dcm, 1'b1));
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_motor_cmd want;
        if (!i_rst_n) begin
            cfg = '{critical_cm: 10'd40, warning_cm: 10'd80, safe_cm: 10'd120,
                    backup_ms: 8'd70, brake_ms: 8'd15, turn_ms: 8'd50,
                    backup_speed: 8'd150, slow_speed: 8'd100};
            motor_cmds.delete();
            echo_sum = '0;
            window_fill = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                beats++;
                if (motor_cmds.size() == 0) begin
                    mismatches++;
                    $display("%0t: command beat mismatch, expected none, actual last %0d",
                             $time, i_last);
                end else begin
                    want = motor_cmds.pop_front();
                    check_field("left_dir", want.left_dir, i_left_dir);
                    check_field("right_dir", want.right_dir, i_right_dir);
                    check_field("left_duty", want.left_duty, i_left_duty);
                    check_field("right_duty", want.right_duty, i_right_duty);
                    check_field("hold_ms", want.hold_ms, i_hold_ms);
                    check_field("distance_cm", want.distance_cm, i_distance_cm);
                    check_field("last", want.last, i_last);
                end
            end
            if (i_in_valid && !i_in_stall) take_echo(i_echo_us);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CRITICAL:     cfg.critical_cm = i_cfg_data;
                    CFG_WARNING:      cfg.warning_cm = i_cfg_data;
                    CFG_SAFE:         cfg.safe_cm = i_cfg_data;
                    CFG_BACKUP_MS:    cfg.backup_ms = i_cfg_data[HOLD_W-1:0];
                    CFG_BRAKE_MS:     cfg.brake_ms = i_cfg_data[HOLD_W-1:0];
                    CFG_TURN_MS:      cfg.turn_ms = i_cfg_data[HOLD_W-1:0];
                    CFG_BACKUP_SPEED: cfg.backup_speed = i_cfg_data[DUTY_W-1:0];
                    CFG_SLOW_SPEED:   cfg.slow_speed = i_cfg_data[DUTY_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatches;
        o_pending <= motor_cmds.size();
        o_beats <= beats;
    end

endmodule

FILE: test/tb_ultrasonic_obstacle_avoid_sequencer.sv
`timescale 1ns / 100ps

module tb_ultrasonic_obstacle_avoid_sequencer;
    import uoas_pkg::*;

    localparam int SAMPLES        = 5;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ECHO_MAX       = 65535;
    localparam int D16_MAX        = ECHO_MAX * 272 / 1000;
    localparam int RAND_PHASES    = 6;

    typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_EVERY4, STALL_LONG} t_stall_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic [ECHO_W-1:0]  i_echo_us = '0;
    logic               i_out_stall = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [IDX_W-1:0]   i_cfg_index = CFG_CRITICAL;
    logic [CM_W-1:0]    i_cfg_data = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic [DIR_W-1:0]   o_left_dir;
    logic [DIR_W-1:0]   o_right_dir;
    logic [DUTY_W-1:0]  o_left_duty;
    logic [DUTY_W-1:0]  o_right_duty;
    logic [HOLD_W-1:0]  o_hold_ms;
    logic [DCM_W-1:0]   o_distance_cm;
    logic               o_last;
    logic               o_cfg_ready;

    int          fail_count;
    int          pending;
    int          beats;
    int          crit_cm = 40;
    int          warn_cm = 80;
    int          safe_cm = 120;
    int          burst_left = 0;
    bit          quiet = 1'b0;
    int          n_echo = 0;
    int          n_cfg = 0;
    int          n_settings = 1;
    int          idle_cycles = 0;
    logic [31:0] cyc = '0;
    t_stall_mode stall_mode = STALL_NONE;

    ultrasonic_obstacle_avoid_sequencer #(.SAMPLES(SAMPLES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_echo_us(i_echo_us),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_left_dir(o_left_dir), .o_right_dir(o_right_dir),
        .o_left_duty(o_left_duty), .o_right_duty(o_right_duty),
        .o_hold_ms(o_hold_ms), .o_distance_cm(o_distance_cm), .o_last(o_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    uoas_checker #(.SAMPLES(SAMPLES)) u_cmd_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_echo_us(i_echo_us),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_left_dir(o_left_dir), .i_right_dir(o_right_dir),
        .i_left_duty(o_left_duty), .i_right_duty(o_right_duty),
        .i_hold_ms(o_hold_ms), .i_distance_cm(o_distance_cm), .i_last(o_last),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_beats(beats)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc[5:0] == 6'd0) stall_mode <= t_stall_mode'($urandom_range(3, 0));
        case (stall_mode)
            STALL_NONE:   i_out_stall <= 1'b0;
            STALL_COIN:   i_out_stall <= 1'($urandom_range(1, 0));
            STALL_EVERY4: i_out_stall <= (cyc[1:0] == 2'd0);
            default:      i_out_stall <= (cyc[3:0] != 4'd0);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_echo(input logic [ECHO_W-1:0] echo);
        int gap;
        if (burst_left == 0) begin
            gap = quiet ? 0 : $urandom_range(6, 0);
            burst_left = $urandom_range(12, 1);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_echo_us <= echo;
        do @(posedge i_clk); while (o_in_stall);
        n_echo++;
    endtask

    // one full window whose average lands exactly on d16 = target
    task automatic send_window(input int target);
        longint total;
        longint lo;
        longint hi;
        int     part;
        if (target < 0) target = 0;
        if (target > D16_MAX) target = D16_MAX;
        total = (longint'(target) * 1000 * SAMPLES + 271) / 272;
        for (int k = 0; k < SAMPLES; k++) begin
            if (k == SAMPLES - 1) begin
                part = int'(total);
            end else begin
                lo = total - longint'(SAMPLES - 1 - k) * ECHO_MAX;
                if (lo < 0) lo = 0;
                hi = (total < ECHO_MAX) ? total : ECHO_MAX;
                part = $urandom_range(int'(hi), int'(lo));
            end
            send_echo(ECHO_W'(part));
            total -= part;
        end
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CM_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        n_cfg++;
    endtask

    task automatic apply_settings(input int c, input int w, input int s, input int bms,
                                  input int brms, input int tms, input int bsp, input int ssp);
        cfg_write(CFG_CRITICAL, CM_W'(c));
        cfg_write(CFG_WARNING, CM_W'(w));
        cfg_write(CFG_SAFE, CM_W'(s));
        // upper data bits are junk for the 8-bit registers
        cfg_write(CFG_BACKUP_MS, {2'($urandom_range(3, 0)), 8'(bms)});
        cfg_write(CFG_BRAKE_MS, {2'($urandom_range(3, 0)), 8'(brms)});
        cfg_write(CFG_TURN_MS, {2'($urandom_range(3, 0)), 8'(tms)});
        cfg_write(CFG_BACKUP_SPEED, {2'($urandom_range(3, 0)), 8'(bsp)});
        cfg_write(CFG_SLOW_SPEED, {2'($urandom_range(3, 0)), 8'(ssp)});
        i_cfg_valid <= 1'b0;
        crit_cm = c & 10'h3FF;
        warn_cm = w & 10'h3FF;
        safe_cm = s & 10'h3FF;
        n_settings++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_window();
        case ($urandom_range(9, 0))
            0, 1:    send_window(16 * crit_cm + int'($urandom_range(6, 0)) - 3);
            2, 3:    send_window(16 * warn_cm + int'($urandom_range(6, 0)) - 3);
            4:       send_window(16 * safe_cm + int'($urandom_range(6, 0)) - 3);
            5, 6, 7: send_window($urandom_range(D16_MAX, 0));
            8:       repeat (SAMPLES) send_echo(ECHO_W'($urandom_range(ECHO_MAX, 0)));
            default: send_window($urandom_range(1, 0) ? 0 : D16_MAX);
        endcase
    endtask

    initial begin
        int c;
        int w;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: all-zero and all-one echoes, critical edge, warning edge
        quiet = 1'b1;
        repeat (SAMPLES) send_echo('0);
        repeat (SAMPLES) send_echo('1);
        send_window(16 * crit_cm);
        send_window(16 * crit_cm + 1);
        send_window(16 * warn_cm);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: apply_settings(1023, 1023, 1023, 255, 255, 255, 255, 255);
                1: apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
                2: apply_settings(300, 100, 50, $urandom_range(255, 0), $urandom_range(255, 0),
                                  $urandom_range(255, 0), $urandom_range(255, 0),
                                  $urandom_range(255, 0));
                3: apply_settings(1, 2, 1, $urandom_range(255, 0), $urandom_range(255, 0),
                                  $urandom_range(255, 0), $urandom_range(255, 0),
                                  $urandom_range(255, 0));
                default: begin
                    c = $urandom_range(200, 0);
                    w = c + $urandom_range(200, 0);
                    apply_settings(c, w, w + $urandom_range(300, 1), $urandom_range(255, 0),
                                   $urandom_range(255, 0), $urandom_range(255, 0),
                                   $urandom_range(255, 0), $urandom_range(255, 0));
                end
            endcase
            quiet = (p == 3);
            repeat (5) random_window();
            drain();
        end

        @(negedge i_clk);
        $display("%0d echo samples in %0d windows, %0d register writes across %0d settings",
                 n_echo, n_echo / SAMPLES, n_cfg, n_settings);
        $display("%0d command beats compared, %0d mismatches", beats, fail_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
